// ----- hdl/hmws_pkg.sv -----
// Shared types and constants for the minimum Hamming distance window scanner.
package hmws_pkg;

    localparam int PATTERN_BITS   = 64;
    localparam int LENGTH_BITS    = 6;
    localparam int CODE_BITS      = 3;
    localparam int MIN_BITS       = 6;
    localparam int TOTAL_OUT_BITS = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int RESET_LENGTH   = 20;
    localparam int GROUP_BITS     = 8;
    localparam int PART_BITS      = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_BASES  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd1;

    typedef struct packed {
        logic [CODE_BITS-1:0] base_code;
        logic                 last_base;
        logic                 last_genome;
    } hmws_in_t;

    typedef struct packed {
        logic [MIN_BITS-1:0]       genome_min;
        logic [TOTAL_OUT_BITS-1:0] running_total;
    } hmws_out_t;

    typedef struct packed {
        logic valid;
        logic window_ok;
        logic last_base;
        logic last_genome;
    } hmws_stage_t;

    typedef struct packed {
        logic                   restart;
        logic [LENGTH_BITS-1:0] length;
    } hmws_restart_t;

endpackage

// ----- hdl/min_hamming_window_scan.sv -----
// Top level of the streaming minimum Hamming distance window scanner.
// Genome bases enter one per request and are matched against the configured primer
// pattern over every full window of the current genome; on a genome's last base one
// result carries the least mismatch count and the saturating running total. The block
// takes one base every clock cycle unless back pressure stalls it. A genome's last base
// passes from the input register through the compare and mismatch-count stage, which works
// from the input register, to the minimum and total stage, which loads the result register.
// Back pressure on the result side holds a genome's last base in the compare stage while
// an earlier result is still waiting, and the bases behind it stall with it. Writing the
// pattern length restarts the current genome; configuration is expected only while no
// bases are in flight.
module min_hamming_window_scan
    import hmws_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int TOTAL_BITS  = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  hmws_in_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hmws_out_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PATTERN_BITS-1:0]   cfg_data
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int NG = (PATTERN_MAX + GROUP_BITS - 1) / GROUP_BITS;

    logic [LW-1:0]                 eff_len;
    logic [PATTERN_MAX-1:0][1:0]   ref_pat;
    logic [PATTERN_MAX-1:0]        ref_mask;
    hmws_restart_t                 restart;
    logic                          mid_take;
    hmws_stage_t                   mid_ctl;
    logic [NG-1:0][PART_BITS-1:0]  mid_part;

    hmws_cfg #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .eff_len  (eff_len),
        .ref_pat  (ref_pat),
        .ref_mask (ref_mask),
        .restart  (restart)
    );

    hmws_match #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .eff_len (eff_len),
        .ref_pat (ref_pat),
        .ref_mask(ref_mask),
        .restart (restart),
        .mid_take(mid_take),
        .mid_ctl (mid_ctl),
        .mid_part(mid_part)
    );

    hmws_accum #(
        .PATTERN_MAX(PATTERN_MAX),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eff_len (eff_len),
        .restart (restart),
        .mid_ctl (mid_ctl),
        .mid_part(mid_part),
        .mid_take(mid_take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/hmws_cfg.sv -----
// Configuration registers and the prepared, reversed pattern used by the compare stage.
module hmws_cfg
    import hmws_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
    input  logic [PATTERN_BITS-1:0]               cfg_data,
    output logic [$clog2(PATTERN_MAX+1)-1:0]      eff_len,
    output logic [PATTERN_MAX-1:0][1:0]           ref_pat,
    output logic [PATTERN_MAX-1:0]                ref_mask,
    output hmws_restart_t                         restart
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);

    logic [PATTERN_BITS-1:0]      pattern_reg;
    logic [LENGTH_BITS-1:0]       length_reg;
    logic [LW-1:0]                eff_len_reg;
    logic [PATTERN_MAX-1:0][1:0]  ref_pat_reg;
    logic [PATTERN_MAX-1:0]       ref_mask_reg;
    logic [LW-1:0]                cur_len;
    logic [PATTERN_MAX-1:0][1:0]  ref_pat_next;
    logic [PATTERN_MAX-1:0]       ref_mask_next;
    logic                         wr;

    function automatic logic [LW-1:0] clamp_len(input logic [LENGTH_BITS-1:0] raw);
        logic [LW-1:0] r;
        if (raw == '0) begin
            r = LW'(1);
        end else if (raw > LENGTH_BITS'(PATTERN_MAX)) begin
            r = LW'(PATTERN_MAX);
        end else begin
            r = LW'(raw);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LENGTH_BITS'(RESET_LENGTH);
        end else if (wr) begin
            case (cfg_index)
                CFG_PATTERN_BASES: begin
                    pattern_reg <= cfg_data;
                end
                CFG_PATTERN_LENGTH: begin
                    length_reg <= cfg_data[LENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Window entry k holds the k-th newest base, so it meets pattern base len-1-k.
    always_comb begin
        logic [IW-1:0] pos;
        cur_len = clamp_len(length_reg);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pos = IW'(cur_len - LW'(k) - LW'(1));
            ref_mask_next[k] = LW'(k) < cur_len;
            ref_pat_next[k]  = ref_mask_next[k] ? pattern_reg[2*pos +: 2] : 2'b00;
        end
    end

    always_ff @(posedge aclk) begin
        eff_len_reg  <= cur_len;
        ref_pat_reg  <= ref_pat_next;
        ref_mask_reg <= ref_mask_next;
    end

    assign eff_len  = eff_len_reg;
    assign ref_pat  = ref_pat_reg;
    assign ref_mask = ref_mask_reg;

    always_comb begin
        restart.restart = wr && (cfg_index == CFG_PATTERN_LENGTH);
        restart.length  = LENGTH_BITS'(clamp_len(cfg_data[LENGTH_BITS-1:0]));
    end

endmodule

// ----- hdl/hmws_match.sv -----
// Input register, base window shift line and per-window mismatch counting stage.
module hmws_match
    import hmws_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  hmws_in_t                                          s_data,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]                  eff_len,
    input  logic [PATTERN_MAX-1:0][1:0]                       ref_pat,
    input  logic [PATTERN_MAX-1:0]                            ref_mask,
    input  hmws_restart_t                                     restart,
    input  logic                                              mid_take,
    output hmws_stage_t                                       mid_ctl,
    output logic [(PATTERN_MAX+GROUP_BITS-1)/GROUP_BITS-1:0][PART_BITS-1:0] mid_part
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int NG = (PATTERN_MAX + GROUP_BITS - 1) / GROUP_BITS;

    logic                                  in_valid_reg;
    hmws_in_t                              in_data_reg;
    logic [CODE_BITS-1:0]                  win_reg  [PATTERN_MAX];
    logic [CODE_BITS-1:0]                  win_next [PATTERN_MAX];
    logic [LW-1:0]                         fill_reg;
    logic [LW-1:0]                         fill_next;
    logic                                  window_ok;
    logic [NG*GROUP_BITS-1:0]              miss_vec;
    logic [NG-1:0][PART_BITS-1:0]          part_next;
    hmws_stage_t                           mid_ctl_reg;
    logic [NG-1:0][PART_BITS-1:0]          mid_part_reg;
    logic                                  mid_free;
    logic                                  adv;

    assign mid_free = !mid_ctl_reg.valid || mid_take;
    assign adv      = in_valid_reg && mid_free;
    assign s_ready  = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_comb begin
        win_next[0] = in_data_reg.base_code;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            win_reg <= win_next;
        end
    end

    assign fill_next = (fill_reg < LW'(PATTERN_MAX)) ? fill_reg + LW'(1) : fill_reg;
    assign window_ok = fill_next >= eff_len;

    // Codes above 3 never equal the zero-extended pattern base.
    always_comb begin
        miss_vec = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            miss_vec[k] = ref_mask[k] && (win_next[k] != {1'b0, ref_pat[k]});
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            part_next[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++) begin
                part_next[g] = part_next[g] + PART_BITS'(miss_vec[g*GROUP_BITS+b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (restart.restart) begin
            fill_reg <= '0;
        end else if (adv) begin
            fill_reg <= in_data_reg.last_base ? '0 : fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_ctl_reg <= '0;
        end else if (mid_free) begin
            mid_ctl_reg.valid       <= in_valid_reg;
            mid_ctl_reg.window_ok   <= window_ok;
            mid_ctl_reg.last_base   <= in_data_reg.last_base;
            mid_ctl_reg.last_genome <= in_data_reg.last_genome;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mid_part_reg <= part_next;
        end
    end

    assign mid_ctl  = mid_ctl_reg;
    assign mid_part = mid_part_reg;

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LW'(PATTERN_MAX))
        else $error("Fill count ran past the window depth.");

    a_take_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_take |-> mid_ctl_reg.valid)
        else $error("The accumulate stage took an empty mismatch stage.");

endmodule

// ----- hdl/hmws_accum.sv -----
// Minimum tracking, saturating total over genomes and the result register.
module hmws_accum
    import hmws_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int TOTAL_BITS  = 24
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]                  eff_len,
    input  hmws_restart_t                                     restart,
    input  hmws_stage_t                                       mid_ctl,
    input  logic [(PATTERN_MAX+GROUP_BITS-1)/GROUP_BITS-1:0][PART_BITS-1:0] mid_part,
    output logic                                              mid_take,
    output logic                                              m_valid,
    input  logic                                              m_ready,
    output hmws_out_t                                         m_data
);

    localparam int LW        = $clog2(PATTERN_MAX + 1);
    localparam int NG        = (PATTERN_MAX + GROUP_BITS - 1) / GROUP_BITS;
    localparam int SW        = TOTAL_BITS + 1;
    localparam int OUT_TB    = (TOTAL_BITS < TOTAL_OUT_BITS) ? TOTAL_BITS : TOTAL_OUT_BITS;
    localparam int RESET_LEN = (PATTERN_MAX < RESET_LENGTH) ? PATTERN_MAX : RESET_LENGTH;

    logic [LW-1:0]         best_reg;
    logic [TOTAL_BITS-1:0] sum_reg;
    logic                  m_valid_reg;
    logic [LW-1:0]         min_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [LW-1:0]         miss;
    logic [LW-1:0]         cand;
    logic [SW-1:0]         sum_ext;
    logic [TOTAL_BITS-1:0] sum_sat;
    logic                  out_free;
    logic                  result;

    always_comb begin
        miss = '0;
        for (int g = 0; g < NG; g++) begin
            miss = miss + LW'(mid_part[g]);
        end
    end

    assign cand     = (mid_ctl.window_ok && (miss < best_reg)) ? miss : best_reg;
    assign sum_ext  = {1'b0, sum_reg} + SW'(cand);
    assign sum_sat  = sum_ext[TOTAL_BITS] ? '1 : sum_ext[TOTAL_BITS-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign mid_take = mid_ctl.valid && (!mid_ctl.last_base || out_free);
    assign result   = mid_take && mid_ctl.last_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= LW'(RESET_LEN);
            sum_reg  <= '0;
        end else if (restart.restart) begin
            best_reg <= LW'(restart.length);
        end else if (mid_take) begin
            if (mid_ctl.last_base) begin
                best_reg <= eff_len;
                sum_reg  <= mid_ctl.last_genome ? '0 : sum_sat;
            end else begin
                best_reg <= cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result) begin
            min_reg   <= cand;
            total_reg <= sum_sat;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_data.genome_min    = MIN_BITS'(min_reg);
    assign m_data.running_total = TOTAL_OUT_BITS'(total_reg[OUT_TB-1:0]);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (sum_reg == '0) && !m_valid_reg)
        else $error("Reset did not clear the running total and result flag.");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        result |=> m_valid_reg)
        else $error("A genome's last base produced no result.");

    a_min_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (min_reg <= LW'(PATTERN_MAX)) && (best_reg <= LW'(PATTERN_MAX)))
        else $error("Mismatch minimum exceeds the pattern depth.");

endmodule
